// ===== rtl/mbwc_pkg.sv =====
// ----------------------------------------------------------------------------
// mbwc_pkg: shared types and constants of the multibyte to wide char decoder
// Holds encoding codes, status codes, lead byte values and the sequence state.
// ----------------------------------------------------------------------------
package mbwc_pkg;

  // Encoding register codes (5..7 behave as Latin-1)
  localparam logic [2:0] ENC_EUC_JP = 3'd0;
  localparam logic [2:0] ENC_EUC_CN = 3'd1;
  localparam logic [2:0] ENC_EUC_TW = 3'd2;
  localparam logic [2:0] ENC_UTF8   = 3'd3;
  localparam logic [2:0] ENC_LATIN1 = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  // EUC single shift lead bytes
  localparam logic [7:0] LEAD_SS2 = 8'h8e;
  localparam logic [7:0] LEAD_SS3 = 8'h8f;

  // Kind of the sequence in progress
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_JP_SS2 = 3'd1,
    KIND_CN_SS2 = 3'd2,
    KIND_TW_SS2 = 3'd3,
    KIND_SS3    = 3'd4,
    KIND_HIGH   = 3'd5,
    KIND_UTF2   = 3'd6,
    KIND_UTF3   = 3'd7
  } kind_e;

  // Sequence state carried between bytes
  typedef struct packed {
    logic [23:0] gathered;
    logic [1:0]  left;
    kind_e       kind;
  } seq_state_t;

  // One result item
  typedef struct packed {
    logic [23:0] wide_char;
    logic [1:0]  status;
    logic        end_of_string;
  } result_t;

  localparam seq_state_t SEQ_IDLE = '{gathered: 24'h0, left: 2'd0, kind: KIND_NONE};

endpackage

// ===== rtl/mbwc_in_if.sv =====
// ----------------------------------------------------------------------------
// mbwc_in_if: byte input channel
// Valid/ready channel carrying one byte of the string and its last flag.
// ----------------------------------------------------------------------------
interface mbwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== rtl/mbwc_out_if.sv =====
// ----------------------------------------------------------------------------
// mbwc_out_if: wide character output channel
// Valid/ready channel carrying one decoded character with status flags.
// ----------------------------------------------------------------------------
interface mbwc_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] wide_char;
  logic [1:0]  status;
  logic        end_of_string;

  modport source (output valid, output wide_char, output status, output end_of_string,
                  input ready);
  modport sink   (input valid, input wide_char, input status, input end_of_string,
                  output ready);
endinterface

// ===== rtl/mbwc_step.sv =====
// ----------------------------------------------------------------------------
// mbwc_step: next-state and result logic for one byte
// Classifies a lead byte or packs a trail byte into the sequence state.
// ----------------------------------------------------------------------------
module mbwc_step import mbwc_pkg::*; (
  input  seq_state_t  cur_i,
  input  logic [2:0]  encoding_i,
  input  logic [7:0]  in_byte_i,
  input  logic        last_i,
  output seq_state_t  nxt_o,
  output logic        emit_o,
  output result_t     res_o
);

  always_comb begin
    logic        started;
    logic [23:0] g;
    started = 1'b0;
    g       = cur_i.gathered;
    nxt_o   = cur_i;
    emit_o  = 1'b0;
    res_o   = '{wide_char: 24'h0, status: ST_OK, end_of_string: 1'b0};

    if (cur_i.left == 2'd0) begin
      // Lead byte: classify it
      if (in_byte_i == 8'h00) begin
        emit_o = 1'b1;
        res_o  = '{wide_char: 24'h0, status: ST_OK, end_of_string: 1'b1};
        nxt_o  = SEQ_IDLE;
      end else if (encoding_i inside {ENC_EUC_JP, ENC_EUC_CN, ENC_EUC_TW}) begin
        if (in_byte_i == LEAD_SS2) begin
          started        = 1'b1;
          nxt_o.gathered = 24'h0;
          case (encoding_i)
            ENC_EUC_JP: begin
              nxt_o.kind = KIND_JP_SS2;
              nxt_o.left = 2'd1;
            end
            ENC_EUC_CN: begin
              nxt_o.kind = KIND_CN_SS2;
              nxt_o.left = 2'd2;
            end
            default: begin
              nxt_o.kind = KIND_TW_SS2;
              nxt_o.left = 2'd3;
            end
          endcase
        end else if (in_byte_i == LEAD_SS3) begin
          started        = 1'b1;
          nxt_o.gathered = 24'h0;
          nxt_o.kind     = KIND_SS3;
          nxt_o.left     = 2'd2;
        end else if (in_byte_i[7]) begin
          started        = 1'b1;
          nxt_o.gathered = {8'h00, in_byte_i, 8'h00};
          nxt_o.kind     = KIND_HIGH;
          nxt_o.left     = 2'd1;
        end else begin
          emit_o = 1'b1;
          res_o  = '{wide_char: {16'h0, in_byte_i}, status: ST_OK, end_of_string: last_i};
        end
      end else if (encoding_i == ENC_UTF8) begin
        if (!in_byte_i[7]) begin
          emit_o = 1'b1;
          res_o  = '{wide_char: {16'h0, in_byte_i}, status: ST_OK, end_of_string: last_i};
        end else if (in_byte_i[7:5] == 3'b110) begin
          started        = 1'b1;
          nxt_o.gathered = {13'h0, in_byte_i[4:0], 6'h00};
          nxt_o.kind     = KIND_UTF2;
          nxt_o.left     = 2'd1;
        end else if (in_byte_i[7:5] == 3'b111) begin
          started        = 1'b1;
          nxt_o.gathered = {8'h00, in_byte_i[3:0], 12'h000};
          nxt_o.kind     = KIND_UTF3;
          nxt_o.left     = 2'd2;
        end else begin
          // Continuation byte in lead position: drop it and flag
          emit_o = 1'b1;
          res_o  = '{wide_char: 24'h0, status: ST_INVALID, end_of_string: last_i};
        end
      end else begin
        emit_o = 1'b1;
        res_o  = '{wide_char: {16'h0, in_byte_i}, status: ST_OK, end_of_string: last_i};
      end

      // String ends right after a lead byte
      if (started && last_i) begin
        emit_o = 1'b1;
        res_o  = '{wide_char: nxt_o.gathered, status: ST_TRUNCATED, end_of_string: 1'b1};
        nxt_o  = SEQ_IDLE;
      end
    end else begin
      // Trail byte: pack it by sequence kind
      case (cur_i.kind)
        KIND_JP_SS2: g = {16'h0, in_byte_i};
        KIND_CN_SS2: begin
          if (cur_i.left == 2'd2) begin
            g = {10'h0, in_byte_i[5:0], 8'h00};
          end else begin
            g = cur_i.gathered | {16'h0, in_byte_i};
          end
        end
        KIND_TW_SS2: g = {cur_i.gathered[15:0], in_byte_i};
        KIND_SS3: begin
          if (cur_i.left == 2'd2) begin
            g = {8'h00, in_byte_i, 8'h00};
          end else begin
            g = cur_i.gathered | {18'h0, in_byte_i[5:0]};
          end
        end
        KIND_HIGH: g = cur_i.gathered | {16'h0, in_byte_i};
        KIND_UTF2: g = cur_i.gathered | {18'h0, in_byte_i[5:0]};
        KIND_UTF3: begin
          if (cur_i.left == 2'd2) begin
            g = cur_i.gathered | {12'h0, in_byte_i[5:0], 6'h00};
          end else begin
            g = cur_i.gathered | {18'h0, in_byte_i[5:0]};
          end
        end
        default: g = cur_i.gathered;
      endcase
      nxt_o.gathered = g;
      nxt_o.left     = cur_i.left - 2'd1;

      if (nxt_o.left == 2'd0) begin
        emit_o = 1'b1;
        res_o  = '{wide_char: g, status: ST_OK, end_of_string: last_i};
        nxt_o  = SEQ_IDLE;
      end else if (last_i) begin
        emit_o = 1'b1;
        res_o  = '{wide_char: g, status: ST_TRUNCATED, end_of_string: 1'b1};
        nxt_o  = SEQ_IDLE;
      end
    end
  end

endmodule

// ===== rtl/multibyte_to_wide_char_decoder.sv =====
// ----------------------------------------------------------------------------
// multibyte_to_wide_char_decoder: EUC / UTF-8 / Latin-1 to wide char decoder
// Accepts one byte per transaction and produces one wide code per character.
// ----------------------------------------------------------------------------
// A character is registered and appears on the output in the cycle after the
//   transaction that completes it; bytes that complete nothing produce no output.
// Throughput: one byte per cycle, set by the single sequence state register
//   updated on every accepted byte; the output register stalls input only
//   while a held result is not taken.
// Reset: clears the sequence state, the output valid and sets encoding to 0.
module multibyte_to_wide_char_decoder import mbwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  mbwc_in_if.sink    byte_i,
  mbwc_out_if.source char_o
);

  logic [2:0] encoding_q;
  seq_state_t state_q;
  seq_state_t state_d;
  logic       out_valid_q;
  result_t    out_q;
  logic       emit;
  result_t    res;
  logic       in_acc;

  // Take a byte whenever the output register is free or being drained
  assign byte_i.ready = !out_valid_q || char_o.ready;
  assign in_acc       = byte_i.valid && byte_i.ready;

  mbwc_step u_step (
    .cur_i      (state_q),
    .encoding_i (encoding_q),
    .in_byte_i  (byte_i.in_byte),
    .last_i     (byte_i.last_byte),
    .nxt_o      (state_d),
    .emit_o     (emit),
    .res_o      (res)
  );

  // Hold the encoding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoding_q <= ENC_EUC_JP;
    end else if (cfg_we_i) begin
      encoding_q <= cfg_wdata_i;
    end
  end

  // Advance the sequence state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Output valid: set by a result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_q <= 1'b1;
    end else if (char_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_q <= res;
    end
  end

  assign char_o.valid         = out_valid_q;
  assign char_o.wide_char     = out_q.wide_char;
  assign char_o.status        = out_q.status;
  assign char_o.end_of_string = out_q.end_of_string;

  // Idle sequence state carries no leftover bits or kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.left == 2'd0) |-> (state_q.gathered == 24'h0 && state_q.kind == KIND_NONE))
    else $error("idle sequence state not cleared");

  // A result that closes the string leaves the decoder awaiting a lead byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit && res.end_of_string) |=> (state_q.left == 2'd0))
    else $error("sequence still open after end of string");

  // A truncated result always closes the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_TRUNCATED) |-> out_q.end_of_string)
    else $error("truncated status without end of string");

  // A stalled output must not be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !char_o.ready) |-> !in_acc)
    else $error("input accepted while output stalled");

endmodule

// ===== tb/multibyte_to_wide_char_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// multibyte_to_wide_char_decoder_tb: self-checking bench for the decoder
// Streams byte strings in every encoding setting through the valid/ready
// input, predicts each wide character in the bench and checks the output
// channel field by field. Both sides idle in random bursts, the receiver
// holds off for a long stretch twice, and the encoding changes between phases,
// also while a sequence is still open.
// ----------------------------------------------------------------------------
module multibyte_to_wide_char_decoder_tb;
  import mbwc_pkg::*;

  // Encoding values 5..7 alias Latin-1; 7 is the top of the register range
  localparam logic [2:0] ENC_ALIAS_MAX = 3'd7;
  localparam logic [7:0] NUL_BYTE      = 8'h00;

  localparam int ITEMS_TARGET   = 1450;
  localparam int PHASE_ITEMS    = 100;
  localparam int QUIET_TAIL     = 200;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;

  mbwc_in_if  byte_if ();
  mbwc_out_if char_if ();

  multibyte_to_wide_char_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_if),
    .char_o      (char_if)
  );

  // Bench copy of the decoder state
  logic [2:0]  dec_enc;
  logic [23:0] dec_gathered;
  logic [1:0]  dec_left;
  kind_e       dec_kind;

  byte_item_t pending_bytes[$];
  result_t    expected_chars[$];

  bit byte_taken;
  int src_gap, sink_gap, src_idle_pct, sink_idle_pct;
  int hold_reqs, hold_served, hold_cnt;
  int bytes_sent, bytes_taken_cnt, chars_checked, phases_run;
  int mismatches, errors;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advance the decoder state by one byte; returns 1 when a character is due
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output result_t r);
    r = '0;
    if (dec_left == 2'd0) begin
      // Lead byte position
      if (b == NUL_BYTE) begin
        dec_gathered = '0; dec_left = '0; dec_kind = KIND_NONE;
        r = '{wide_char: 24'h0, status: ST_OK, end_of_string: 1'b1};
        return 1'b1;
      end
      if (dec_enc <= ENC_EUC_TW) begin
        if (b == LEAD_SS2) begin
          case (dec_enc)
            ENC_EUC_JP: begin dec_kind = KIND_JP_SS2; dec_left = 2'd1; end
            ENC_EUC_CN: begin dec_kind = KIND_CN_SS2; dec_left = 2'd2; end
            default:    begin dec_kind = KIND_TW_SS2; dec_left = 2'd3; end
          endcase
          dec_gathered = '0;
        end else if (b == LEAD_SS3) begin
          dec_kind = KIND_SS3; dec_left = 2'd2; dec_gathered = '0;
        end else if (b[7]) begin
          dec_kind = KIND_HIGH; dec_left = 2'd1; dec_gathered = {8'h0, b, 8'h0};
        end else begin
          r = '{wide_char: {16'h0, b}, status: ST_OK, end_of_string: last};
          return 1'b1;
        end
      end else if (dec_enc == ENC_UTF8) begin
        if (!b[7]) begin
          r = '{wide_char: {16'h0, b}, status: ST_OK, end_of_string: last};
          return 1'b1;
        end else if (b[7:5] == 3'b110) begin
          dec_kind = KIND_UTF2; dec_left = 2'd1; dec_gathered = {13'h0, b[4:0], 6'h0};
        end else if (b[7:5] == 3'b111) begin
          dec_kind = KIND_UTF3; dec_left = 2'd2; dec_gathered = {8'h0, b[3:0], 12'h0};
        end else begin
          // Continuation byte where a lead belongs: consume and flag
          r = '{wide_char: 24'h0, status: ST_INVALID, end_of_string: last};
          return 1'b1;
        end
      end else begin
        r = '{wide_char: {16'h0, b}, status: ST_OK, end_of_string: last};
        return 1'b1;
      end
      if (last) begin
        r = '{wide_char: dec_gathered, status: ST_TRUNCATED, end_of_string: 1'b1};
        dec_gathered = '0; dec_left = '0; dec_kind = KIND_NONE;
        return 1'b1;
      end
      return 1'b0;
    end

    // Trail byte: pack according to the kind chosen at the lead
    case (dec_kind)
      KIND_JP_SS2: dec_gathered = {16'h0, b};
      KIND_CN_SS2: begin
        if (dec_left == 2'd2) dec_gathered = {10'h0, b[5:0], 8'h0};
        else                  dec_gathered = dec_gathered | {16'h0, b};
      end
      KIND_TW_SS2: dec_gathered = {dec_gathered[15:0], b};
      KIND_SS3: begin
        if (dec_left == 2'd2) dec_gathered = {8'h0, b, 8'h0};
        else                  dec_gathered = dec_gathered | {18'h0, b[5:0]};
      end
      KIND_HIGH:   dec_gathered = dec_gathered | {16'h0, b};
      KIND_UTF2:   dec_gathered = dec_gathered | {18'h0, b[5:0]};
      KIND_UTF3: begin
        if (dec_left == 2'd2) dec_gathered = dec_gathered | {12'h0, b[5:0], 6'h0};
        else                  dec_gathered = dec_gathered | {18'h0, b[5:0]};
      end
      default: ;
    endcase
    dec_left = dec_left - 2'd1;
    if (dec_left == 2'd0 || last) begin
      r = '{wide_char: dec_gathered, status: (dec_left == 2'd0) ? ST_OK : ST_TRUNCATED,
            end_of_string: (dec_left == 2'd0) ? last : 1'b1};
      dec_gathered = '0; dec_left = '0; dec_kind = KIND_NONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Byte driver: offer the next pending byte once the current one is taken
  always @(negedge clk_i) begin
    byte_item_t nxt;
    if (rst_ni && (!byte_if.valid || byte_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        byte_if.valid <= 1'b0;
      end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(0, 7);
        byte_if.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        byte_if.valid     <= 1'b1;
        byte_if.in_byte   <= nxt.data;
        byte_if.last_byte <= nxt.last;
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Character receiver: long hold on request, otherwise random stall bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        char_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        char_if.ready <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap = $urandom_range(0, 7);
        char_if.ready <= 1'b0;
      end else begin
        char_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each byte transaction, check each character transaction
  always @(posedge clk_i) begin
    result_t pred;
    result_t want;
    byte_taken = rst_ni && byte_if.valid && byte_if.ready;
    if (byte_taken) begin
      bytes_taken_cnt++;
      if (decode_byte(byte_if.in_byte, byte_if.last_byte, pred))
        expected_chars.push_back(pred);
    end
    if (rst_ni && char_if.valid === 1'b1 && char_if.ready) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected character %h status %0d eos %0b",
                   char_if.wide_char, char_if.status, char_if.end_of_string);
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (char_if.wide_char !== want.wide_char || char_if.status !== want.status ||
            char_if.end_of_string !== want.end_of_string) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("ERROR: char %0d expected %h/%0d/%0b got %h/%0d/%0b", chars_checked,
                     want.wide_char, want.status, want.end_of_string,
                     char_if.wide_char, char_if.status, char_if.end_of_string);
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    pending_bytes.push_back('{data: b, last: last});
    bytes_sent++;
  endtask

  // Write the encoding register while the block is idle
  task automatic set_encoding(input logic [2:0] enc);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enc;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    dec_enc = enc;
  endtask

  // Hold until every byte is taken and every character has come out
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pending_bytes.size() != 0 || byte_if.valid || expected_chars.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Queue one string: mostly well-formed characters, sometimes raw noise
  task automatic queue_string(input logic [2:0] enc);
    byte_item_t str[$];
    int n_chars, ending, cut, start_last, trails, pick, c, t;
    logic [7:0] lead, tb_byte;
    if ($urandom_range(0, 9) == 0) begin
      n_chars = $urandom_range(1, 8);
      for (c = 0; c < n_chars; c++)
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    n_chars = $urandom_range(1, 6);
    start_last = 0;
    for (c = 0; c < n_chars; c++) begin
      start_last = str.size();
      pick = $urandom_range(0, 9);
      if (enc <= ENC_EUC_TW) begin
        if (pick <= 2)      lead = 8'($urandom_range(1, 127));
        else if (pick == 3) lead = LEAD_SS2;
        else if (pick == 4) lead = LEAD_SS3;
        else                lead = 8'($urandom_range(128, 255));
        if (lead == LEAD_SS2) trails = (enc == ENC_EUC_JP) ? 1 : (enc == ENC_EUC_CN) ? 2 : 3;
        else if (lead == LEAD_SS3) trails = 2;
        else trails = lead[7] ? 1 : 0;
      end else if (enc == ENC_UTF8) begin
        if (pick <= 2)      lead = 8'($urandom_range(1, 127));
        else if (pick <= 5) lead = 8'($urandom_range(8'hc0, 8'hdf));
        else if (pick <= 8) lead = 8'($urandom_range(8'he0, 8'hff));
        else                lead = 8'($urandom_range(8'h80, 8'hbf));
        trails = (lead[7:5] == 3'b110) ? 1 : (lead[7:5] == 3'b111) ? 2 : 0;
      end else begin
        lead = 8'($urandom_range(1, 255));
        trails = 0;
      end
      str.push_back('{data: lead, last: 1'b0});
      for (t = 0; t < trails; t++) begin
        if (enc == ENC_UTF8 && $urandom_range(0, 4) != 0)
          tb_byte = 8'($urandom_range(8'h80, 8'hbf));
        else
          tb_byte = 8'($urandom_range(0, 255));
        str.push_back('{data: tb_byte, last: 1'b0});
      end
    end
    // Close the string by length, by NUL, by cutting the last character, or not at all
    ending = $urandom_range(0, 9);
    if (ending <= 4) begin
      str[str.size() - 1].last = 1'b1;
    end else if (ending <= 7) begin
      str.push_back('{data: NUL_BYTE, last: 1'b0});
    end else if (ending == 8 && str.size() - start_last > 1) begin
      cut = $urandom_range(start_last, str.size() - 2);
      while (str.size() > cut + 1) void'(str.pop_back());
      str[cut].last = 1'b1;
    end
    foreach (str[i]) push_byte(str[i].data, str[i].last);
  endtask

  // Stimulus sequencer
  initial begin
    logic [2:0] enc;
    int phase_end;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = ENC_EUC_JP;
    byte_if.valid = 1'b0;
    byte_if.in_byte = 8'h0;
    byte_if.last_byte = 1'b0;
    char_if.ready = 1'b0;
    dec_enc = ENC_EUC_JP;
    dec_gathered = '0;
    dec_left = '0;
    dec_kind = KIND_NONE;
    src_gap = 0; sink_gap = 0; src_idle_pct = 0; sink_idle_pct = 0;
    hold_reqs = 0; hold_served = 0; hold_cnt = 0;
    bytes_sent = 0; bytes_taken_cnt = 0; chars_checked = 0; phases_run = 0;
    mismatches = 0; errors = 0;
    byte_taken = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // EUC-JP: ASCII, SS2, SS3, high-bit pair with a NUL trail, NUL, cut SS2
    set_encoding(ENC_EUC_JP);
    push_byte(8'h41, 1'b0);
    push_byte(LEAD_SS2, 1'b0); push_byte(8'hff, 1'b0);
    push_byte(LEAD_SS3, 1'b0); push_byte(8'h12, 1'b0); push_byte(8'hff, 1'b0);
    push_byte(8'hb0, 1'b0); push_byte(NUL_BYTE, 1'b0);
    push_byte(NUL_BYTE, 1'b0);
    push_byte(LEAD_SS2, 1'b1);
    wait_idle();
    // EUC-CN: SS2 with both trails, then one cut after its first trail
    set_encoding(ENC_EUC_CN);
    push_byte(LEAD_SS2, 1'b0); push_byte(8'hff, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(LEAD_SS2, 1'b0); push_byte(8'h41, 1'b1);
    wait_idle();
    // EUC-TW: three-trail SS2 ending the string, then leave an SS2 open
    set_encoding(ENC_EUC_TW);
    push_byte(LEAD_SS2, 1'b0); push_byte(8'ha1, 1'b0); push_byte(8'hb2, 1'b0);
    push_byte(8'hc3, 1'b1);
    push_byte(LEAD_SS2, 1'b0);
    wait_idle();
    // UTF-8 set mid-sequence: the open SS2 finishes first
    set_encoding(ENC_UTF8);
    push_byte(8'hd4, 1'b0); push_byte(8'he5, 1'b0); push_byte(8'hf6, 1'b0);
    push_byte(8'hc3, 1'b0); push_byte(8'ha9, 1'b0);
    push_byte(8'hff, 1'b0); push_byte(8'hbf, 1'b0); push_byte(8'hbf, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hbf, 1'b1);
    push_byte(8'he2, 1'b1);
    wait_idle();
    // Latin-1 alias at the top of the register range
    set_encoding(ENC_ALIAS_MAX);
    push_byte(8'hff, 1'b0); push_byte(NUL_BYTE, 1'b0);
    wait_idle();

    // Random phases: each encoding in turn, then random ones
    while (bytes_sent < ITEMS_TARGET) begin
      enc = (phases_run < 8) ? 3'(phases_run) : 3'($urandom_range(ENC_EUC_JP, ENC_ALIAS_MAX));
      if (bytes_sent > ITEMS_TARGET - QUIET_TAIL) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = (phases_run % 3 == 0) ? 0 : (phases_run % 3 == 1) ? 10 : 30;
        sink_idle_pct = (phases_run % 4 == 0) ? 0 : (phases_run % 4 == 2) ? 30 : 10;
      end
      set_encoding(enc);
      phase_end = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < phase_end) queue_string(enc);
      // Stall the output long enough to back up the input
      if (phases_run == 2 || phases_run == 9) hold_reqs++;
      wait_idle();
      phases_run++;
    end

    wait_idle();
    if (expected_chars.size() != 0)
      $display("ERROR: %0d characters never came out", expected_chars.size());
    errors = mismatches + expected_chars.size();
    $display("Covered %0d bytes and %0d characters over %0d random encoding phases,",
             bytes_taken_cnt, chars_checked, phases_run);
    $display("with long output holds, input drains and mid-sequence encoding changes.");
    if (errors == 0) begin
      $display("multibyte_to_wide_char_decoder test passed");
    end else begin
      $display("multibyte_to_wide_char_decoder test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("multibyte_to_wide_char_decoder test failed");
    $finish;
  end

endmodule
